### rtl/tokhura_vq_nearest_codeword_unit_defines.svh
// assertion macros for the tokhura vq nearest codeword unit
// used by files that check their own logic; expects clk and rst_n in scope
`ifndef TOKHURA_VQ_NEAREST_CODEWORD_UNIT_DEFINES_SVH
`define TOKHURA_VQ_NEAREST_CODEWORD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TVQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvq assertion failed");
`define TVQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvq assertion failed");
`else
`define TVQ_ASSERT_IMP(label, ante, cons)
`define TVQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

### rtl/tvq_pkg.sv
// shared constants, payload types and the weight table of the vq unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tvq_pkg;

    localparam int CODEBOOK_DEPTH = 32;
    localparam int VECTOR_LEN     = 12;
    localparam int COEFF_BITS     = 16;

    // fixed field widths
    localparam int TYPE_W     = 1;
    localparam int IDX_W      = 5;
    localparam int POS_FIELD_W = 4;
    localparam int VALUE_W    = 16;
    localparam int DIST_W     = 41;
    localparam int CFG_W      = 6;

    localparam int POS_W      = $clog2(VECTOR_LEN);
    localparam int CW_W       = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;
    localparam int CNT_W      = $clog2(CODEBOOK_DEPTH + 1);
    localparam int CB_DEPTH   = CODEBOOK_DEPTH * VECTOR_LEN;
    localparam int CB_ADDR_W  = $clog2(CB_DEPTH);
    localparam int WEIGHT_W   = 6;
    localparam int DIFF_W     = COEFF_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int PROD_W     = SQ_W + WEIGHT_W;
    localparam int ACC_W      = PROD_W + $clog2(VECTOR_LEN);

    localparam logic [TYPE_W-1:0] REQ_LOAD  = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0]         req_type;
        logic [IDX_W-1:0]          codeword_index;
        logic [POS_FIELD_W-1:0]    coeff_position;
        logic signed [VALUE_W-1:0] coeff_value;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
    } res_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [POS_W-1:0] pos;
    } mac_ctl_t;

    function automatic logic [WEIGHT_W-1:0] tok_weight(input logic [POS_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        case (pos)
            POS_W'(0):  w = WEIGHT_W'(1);
            POS_W'(1):  w = WEIGHT_W'(3);
            POS_W'(2):  w = WEIGHT_W'(7);
            POS_W'(3):  w = WEIGHT_W'(13);
            POS_W'(4):  w = WEIGHT_W'(19);
            POS_W'(5):  w = WEIGHT_W'(22);
            POS_W'(6):  w = WEIGHT_W'(25);
            POS_W'(7):  w = WEIGHT_W'(33);
            POS_W'(8):  w = WEIGHT_W'(42);
            POS_W'(9):  w = WEIGHT_W'(50);
            POS_W'(10): w = WEIGHT_W'(56);
            POS_W'(11): w = WEIGHT_W'(61);
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/tvq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tvq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/tvq_mac.sv
// shared weighted square-difference and accumulate pipeline
// depends on tvq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tvq_mac
    import tvq_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mac_ctl_t                     ctl,
    input  wire logic signed [COEFF_BITS-1:0] q_coeff,
    input  wire logic signed [COEFF_BITS-1:0] c_coeff,
    output logic                              dist_valid,
    output logic [ACC_W-1:0]                  cw_dist
);

    mac_ctl_t                s1_ctl_reg;
    mac_ctl_t                s2_ctl_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SQ_W-1:0]   sq_full;
    logic [SQ_W-1:0]          sq_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic                     dist_valid_reg;

    assign diff    = DIFF_W'(q_coeff) - DIFF_W'(c_coeff);
    assign sq_full = SQ_W'(diff) * SQ_W'(diff);

    // first term of a codeword restarts the sum
    assign acc_next = s2_ctl_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg     <= '0;
            s2_ctl_reg     <= '0;
            dist_valid_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg     <= ctl;
            s2_ctl_reg     <= s1_ctl_reg;
            dist_valid_reg <= s2_ctl_reg.valid && s2_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= SQ_W'(sq_full);
        prod_reg <= PROD_W'(sq_reg) * PROD_W'(tok_weight(s1_ctl_reg.pos));
        if (s2_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign dist_valid = dist_valid_reg;
    assign cw_dist    = acc_reg;

endmodule

`default_nettype wire

### rtl/tokhura_vq_nearest_codeword_unit.sv
// Nearest codeword search over a Tokhura-weighted distance. A load transaction
// writes one codebook coefficient; a query transaction stores one query
// coefficient. The query at the last position starts a search: one shared
// square, weight and accumulate pipeline walks the codebook memory one
// coefficient per cycle through the saturated count of codewords, and no
// transaction is taken meanwhile. The memory read port paces the walk. A
// finished result sits in the output register while new transactions are
// taken.
// depends on tvq_pkg, tvq_ram, tvq_mac and the defines header
`timescale 1ns / 1ps
`default_nettype none

`include "tokhura_vq_nearest_codeword_unit_defines.svh"

module tokhura_vq_nearest_codeword_unit
    import tvq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_t             req,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output res_t                  res,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [CFG_W-1:0]          cfg_count_reg;
    logic [CNT_W-1:0]          cnt_sat;
    logic [CB_ADDR_W-1:0]      addr_reg, addr_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [CW_W-1:0]           cw_reg, cw_next;
    logic [CW_W-1:0]           res_cnt_reg, res_cnt_next;
    logic [CW_W-1:0]           best_idx_reg, best_idx_next;
    logic [ACC_W-1:0]          best_dist_reg, best_dist_next;
    logic                      res_valid_reg, res_valid_next;
    res_t                      res_reg;
    mac_ctl_t                  issue_ctl;
    mac_ctl_t                  ctl_d_reg;
    logic signed [COEFF_BITS-1:0] qvec_reg [VECTOR_LEN];
    logic signed [COEFF_BITS-1:0] q_sel_reg;
    logic [COEFF_BITS-1:0]     rd_data;
    logic                      accept;
    logic                      pos_ok;
    logic [POS_W-1:0]          req_pos;
    logic                      load_we;
    logic [CB_ADDR_W-1:0]      load_addr;
    logic                      start;
    logic                      last_pos;
    logic                      last_cw;
    logic                      dist_valid;
    logic [ACC_W-1:0]          cw_dist;
    logic                      last_res;
    logic                      res_load;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    assign pos_ok  = (req.coeff_position < POS_FIELD_W'(VECTOR_LEN));
    assign req_pos = POS_W'(req.coeff_position);
    assign load_we = accept && pos_ok && (req.req_type == REQ_LOAD)
                     && (32'(req.codeword_index) < CODEBOOK_DEPTH);
    assign load_addr = CB_ADDR_W'(req.codeword_index) * CB_ADDR_W'(VECTOR_LEN)
                       + CB_ADDR_W'(req_pos);
    assign start   = accept && (req.req_type == REQ_QUERY)
                     && (req_pos == POS_W'(VECTOR_LEN - 1))
                     && (req.coeff_position == POS_FIELD_W'(VECTOR_LEN - 1));

    // out-of-range counts clamp into 1 .. depth
    always_comb
    begin
        if (cfg_count_reg == '0)
        begin
            cnt_sat = CNT_W'(1);
        end
        else if (32'(cfg_count_reg) > CODEBOOK_DEPTH)
        begin
            cnt_sat = CNT_W'(CODEBOOK_DEPTH);
        end
        else
        begin
            cnt_sat = CNT_W'(cfg_count_reg);
        end
    end

    assign last_pos = (pos_reg == POS_W'(VECTOR_LEN - 1));
    assign last_cw  = (CNT_W'(cw_reg) == cnt_sat - CNT_W'(1));
    assign last_res = (CNT_W'(res_cnt_reg) == cnt_sat - CNT_W'(1));
    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        issue_ctl.valid = (state_reg == S_RUN);
        issue_ctl.first = (pos_reg == '0);
        issue_ctl.last  = last_pos;
        issue_ctl.pos   = pos_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        pos_next   = pos_reg;
        cw_next    = cw_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    addr_next  = '0;
                    pos_next   = '0;
                    cw_next    = '0;
                end
            end
            S_RUN:
            begin
                addr_next = addr_reg + CB_ADDR_W'(1);
                if (last_pos)
                begin
                    pos_next = '0;
                    if (last_cw)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        cw_next = cw_reg + CW_W'(1);
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (dist_valid && last_res)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // distances arrive in codeword order; strict compare keeps the lower index
    always_comb
    begin
        res_cnt_next   = res_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (start)
        begin
            res_cnt_next = '0;
        end
        else if (dist_valid)
        begin
            res_cnt_next = res_cnt_reg + CW_W'(1);
            if ((res_cnt_reg == '0) || (cw_dist < best_dist_reg))
            begin
                best_idx_next  = res_cnt_reg;
                best_dist_next = cw_dist;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_count_reg <= CFG_W'(32);
            addr_reg      <= '0;
            pos_reg       <= '0;
            cw_reg        <= '0;
            res_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            ctl_d_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pos_reg       <= pos_next;
            cw_reg        <= cw_next;
            res_cnt_reg   <= res_cnt_next;
            res_valid_reg <= res_valid_next;
            ctl_d_reg     <= issue_ctl;
            if (cfg_valid && cfg_ready)
            begin
                cfg_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        q_sel_reg     <= qvec_reg[pos_reg];
        if (accept && pos_ok && (req.req_type == REQ_QUERY))
        begin
            qvec_reg[req_pos] <= req.coeff_value[COEFF_BITS-1:0];
        end
        if (res_load)
        begin
            res_reg.best_index    <= IDX_W'(best_idx_reg);
            res_reg.best_distance <= DIST_W'(best_dist_reg);
        end
    end

    tvq_ram #(
        .WIDTH(COEFF_BITS),
        .DEPTH(CB_DEPTH)
    ) u_codebook (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (req.coeff_value[COEFF_BITS-1:0]),
        .re    (issue_ctl.valid),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    tvq_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_d_reg),
        .q_coeff    (q_sel_reg),
        .c_coeff    (rd_data),
        .dist_valid (dist_valid),
        .cw_dist    (cw_dist)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `TVQ_ASSERT_IMP(a_no_dist_when_idle, state_reg == S_IDLE, !dist_valid)
    `TVQ_ASSERT_IMP(a_results_trail_issue, dist_valid, res_cnt_reg <= cw_reg)
    `TVQ_ASSERT_NXT(a_search_starts_clean, start,
        (state_reg == S_RUN) && (res_cnt_reg == '0) && (addr_reg == '0))

endmodule

`default_nettype wire
